[design/assert_macros.svh]
// assertion macros for the rtl files
// no dependencies; included by the decoder unit, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

[design/wav_pkg.sv]
// shared types and constants for the wav pcm header and sample decoder
// no dependencies
`default_nettype none

package wav_pkg;

	// status codes reported on the result channel
	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_SHORT      = 4'd1,
		ST_HEADER     = 4'd2,
		ST_FORM       = 4'd3,
		ST_SUBCHUNK   = 4'd4,
		ST_CHUNK_SIZE = 4'd5,
		ST_COMPRESS   = 4'd6,
		ST_DEPTH      = 4'd7,
		ST_DATA_ID    = 4'd8
	} status_t;

	// four character tags, first byte in the low lane
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// header byte positions
	localparam logic [5:0] POS_FORM_END   = 6'd11;
	localparam logic [5:0] POS_CHUNK_SIZE = 6'd19;
	localparam logic [5:0] POS_FORMAT     = 6'd21;
	localparam logic [5:0] POS_CHANNELS   = 6'd23;
	localparam logic [5:0] POS_RATE       = 6'd27;
	localparam logic [5:0] POS_DEPTH      = 6'd35;
	localparam logic [5:0] POS_LAST       = 6'd43;

	// expected field values
	localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
	localparam logic [15:0] FMT_PCM        = 16'd1;
	localparam logic [15:0] DEPTH_8        = 16'd8;
	localparam logic [15:0] DEPTH_16       = 16'd16;

endpackage

`default_nettype wire

[design/wav_pcm_header_and_sample_decoder_unit.sv]
// wav pcm header checker and sample decoder, one stream byte per beat
// depends on wav_pkg and assert_macros.svh
//
// usage:
//   input channel: data_byte and end_of_stream, with in_valid / in_ready.
//   result channel: one result beat for every input beat, with out_valid /
//   out_ready, carrying sample, sample_valid, channel_index, status,
//   header_done, sample_rate, channel_count and bits_per_sample.
//   the first 44 bytes are checked as the canonical pcm header; the first
//   failing check (or a short stream, which replaces a failure not yet reported) is
//   reported in status and held until reset. after the header every byte (8-bit) or
//   low/high byte pair (16-bit) yields a signed q1.15 sample with an interleaved index.
// output: the result of a beat is registered and appears in the cycle after it is accepted.
// throughput: one byte per cycle unless the receiver stalls; header compare, shift
//   register, sample and channel logic are the per-byte work, in one register stage.
// stall: in_ready stays high while the result register is empty or being
//   drained in the same cycle; a stalled receiver holds the result and stops
//   input after one beat.
// reset: arst_n clears all state but the result payload; the decoder restarts in
//   the header phase with all captured fields zero and no result pending.
`default_nettype none

module wav_pcm_header_and_sample_decoder_unit
	import wav_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_stream,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] sample,
	output logic             sample_valid,
	output logic [15:0]      channel_index,
	output logic [3:0]       status,
	output logic             header_done,
	output logic [31:0]      sample_rate,
	output logic [15:0]      channel_count,
	output logic [4:0]       bits_per_sample
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_ERROR  = 2'd2
	} phase_t;

	// decoder state
	phase_t       phase_q;
	logic [5:0]   hpos_q;
	logic [31:0]  shift_q;
	status_t      err_q;
	logic [31:0]  rate_q;
	logic [15:0]  chans_q;
	logic [4:0]   depth_q;
	logic [7:0]   low_q;
	logic         parity_q;
	logic [15:0]  chan_q;

	// result register
	logic         out_valid_s1;
	logic [15:0]  sample_s1;
	logic         sample_valid_s1;
	logic [15:0]  chan_s1;

	// next values
	phase_t       phase_n;
	logic [5:0]   hpos_n;
	logic [31:0]  shift_n;
	status_t      err_n;
	status_t      code;
	logic [31:0]  rate_n;
	logic [15:0]  chans_n;
	logic [4:0]   depth_n;
	logic [7:0]   low_n;
	logic         parity_n;
	logic [15:0]  chan_n;
	logic [15:0]  samp_n;
	logic         valid_n;
	logic [15:0]  chan_out_n;
	logic [15:0]  half;
	logic [7:0]   tag_riff_b;
	logic [7:0]   tag_wave_b;
	logic [7:0]   tag_fmt_b;
	logic [7:0]   tag_data_b;
	logic [16:0]  chan_inc;
	logic         in_beat;

	assign in_ready = !out_valid_s1 || out_ready;
	assign in_beat  = in_valid && in_ready;

	// expected tag byte for the current lane
	assign tag_riff_b = TAG_RIFF[{hpos_q[1:0], 3'b000} +: 8];
	assign tag_wave_b = TAG_WAVE[{hpos_q[1:0], 3'b000} +: 8];
	assign tag_fmt_b  = TAG_FMT[{hpos_q[1:0], 3'b000} +: 8];
	assign tag_data_b = TAG_DATA[{hpos_q[1:0], 3'b000} +: 8];

	assign shift_n  = {data_byte, shift_q[31:8]};
	assign half     = shift_n[31:16];
	assign chan_inc = {1'b0, chan_q} + 17'd1;

	// header checks for the current position
	always_comb begin
		code = ST_OK;
		case (hpos_q) inside
			[6'd0:6'd3]: begin
				if (data_byte != tag_riff_b) code = ST_HEADER;
			end
			[6'd8:6'd11]: begin
				if (data_byte != tag_wave_b) code = ST_FORM;
			end
			[6'd12:6'd15]: begin
				if (data_byte != tag_fmt_b) code = ST_SUBCHUNK;
			end
			POS_CHUNK_SIZE: begin
				if (shift_n != FMT_CHUNK_SIZE) code = ST_CHUNK_SIZE;
			end
			POS_FORMAT: begin
				if (half != FMT_PCM) code = ST_COMPRESS;
			end
			POS_DEPTH: begin
				if (half != DEPTH_8 && half != DEPTH_16) code = ST_DEPTH;
			end
			[6'd36:6'd39]: begin
				if (data_byte != tag_data_b) code = ST_DATA_ID;
			end
			default: code = ST_OK;
		endcase
	end

	// next state for one accepted byte
	always_comb begin
		phase_n    = phase_q;
		hpos_n     = hpos_q;
		err_n      = err_q;
		rate_n     = rate_q;
		chans_n    = chans_q;
		depth_n    = depth_q;
		low_n      = low_q;
		parity_n   = parity_q;
		chan_n     = chan_q;
		samp_n     = 16'd0;
		valid_n    = 1'b0;
		chan_out_n = 16'd0;
		case (phase_q)
			PH_HEADER: begin
				// field capture only while the chunk is still clean
				if (err_q == ST_OK) begin
					if (hpos_q == POS_CHANNELS) chans_n = half;
					if (hpos_q == POS_RATE) rate_n = shift_n;
					if (hpos_q == POS_DEPTH && code == ST_OK) depth_n = half[4:0];
					err_n = code;
				end
				// chunk boundaries report a pending error
				if (hpos_q == POS_FORM_END || hpos_q == POS_DEPTH || hpos_q == POS_LAST) begin
					if (err_n != ST_OK) phase_n = PH_ERROR;
					else if (hpos_q == POS_LAST) phase_n = PH_DATA;
				end
				if (hpos_q < POS_LAST) hpos_n = hpos_q + 6'd1;
				if (phase_n == PH_HEADER && end_of_stream) begin
					phase_n = PH_ERROR;
					err_n   = ST_SHORT;
				end
			end
			PH_DATA: begin
				if (depth_q == DEPTH_8[4:0]) begin
					samp_n  = {data_byte ^ 8'h80, 8'h00};
					valid_n = 1'b1;
				end else if (!parity_q) begin
					low_n    = data_byte;
					parity_n = 1'b1;
				end else begin
					samp_n   = {data_byte, low_q};
					parity_n = 1'b0;
					valid_n  = 1'b1;
				end
				// interleaved channel counter
				if (valid_n) begin
					chan_out_n = chan_q;
					if (chan_inc >= {1'b0, chans_q}) chan_n = 16'd0;
					else chan_n = chan_inc[15:0];
				end
				if (end_of_stream) begin
					parity_n = 1'b0;
					chan_n   = 16'd0;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hpos_q       <= 6'd0;
			shift_q      <= 32'd0;
			err_q        <= ST_OK;
			rate_q       <= 32'd0;
			chans_q      <= 16'd0;
			depth_q      <= 5'd0;
			low_q        <= 8'd0;
			parity_q     <= 1'b0;
			chan_q       <= 16'd0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (in_beat) begin
				phase_q  <= phase_n;
				hpos_q   <= hpos_n;
				if (phase_q == PH_HEADER) shift_q <= shift_n;
				err_q    <= err_n;
				rate_q   <= rate_n;
				chans_q  <= chans_n;
				depth_q  <= depth_n;
				low_q    <= low_n;
				parity_q <= parity_n;
				chan_q   <= chan_n;
				out_valid_s1 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_s1       <= samp_n;
			sample_valid_s1 <= valid_n;
			chan_s1         <= chan_out_n;
		end
	end

	// captured fields change only together with the result beat
	assign out_valid       = out_valid_s1;
	assign sample          = sample_s1;
	assign sample_valid    = sample_valid_s1;
	assign channel_index   = chan_s1;
	assign status          = (phase_q == PH_ERROR) ? err_q : ST_OK;
	assign header_done     = (phase_q == PH_DATA);
	assign sample_rate     = rate_q;
	assign channel_count   = chans_q;
	assign bits_per_sample = depth_q;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_done_no_err, !(header_done && status != ST_OK),
		"header done with error status")
	`ASSERT_CLK(a_sample_after_hdr, (out_valid && sample_valid) |-> header_done,
		"sample before header done")
	`ASSERT_CLK(a_chan_range,
		(out_valid && sample_valid && channel_count != 16'd0) |->
		(channel_index < channel_count), "channel index out of range")
	`ASSERT_CLK(a_err_hold, (status != ST_OK) |=> (status == $past(status)),
		"error status changed")

endmodule

`default_nettype wire
